// ----- design/nds_pkg.sv -----
`default_nettype none
package nds_pkg;

  // stream widths in bits, padded to whole bytes
  localparam int IN_W  = 72;
  localparam int OUT_W = 24;

  // sequencer states
  localparam logic [4:0] ST_BOOT        = 5'd0;
  localparam logic [4:0] ST_SAFE_IDLE   = 5'd1;
  localparam logic [4:0] ST_MANUAL_IDLE = 5'd2;
  localparam logic [4:0] ST_AUTO_IDLE   = 5'd3;
  localparam logic [4:0] ST_READ        = 5'd4;
  localparam logic [4:0] ST_VALIDATE    = 5'd5;
  localparam logic [4:0] ST_CHECK_LEVEL = 5'd6;
  localparam logic [4:0] ST_FILL        = 5'd7;
  localparam logic [4:0] ST_EVAL_PH     = 5'd8;
  localparam logic [4:0] ST_DOSE_UP     = 5'd9;
  localparam logic [4:0] ST_DOSE_DOWN   = 5'd10;
  localparam logic [4:0] ST_RECIRC_PH   = 5'd11;
  localparam logic [4:0] ST_EVAL_TDS    = 5'd12;
  localparam logic [4:0] ST_DOSE_A      = 5'd13;
  localparam logic [4:0] ST_RECIRC_A    = 5'd14;
  localparam logic [4:0] ST_DOSE_B      = 5'd15;
  localparam logic [4:0] ST_RECIRC_B    = 5'd16;
  localparam logic [4:0] ST_WAIT_STAB   = 5'd17;
  localparam logic [4:0] ST_REMEASURE   = 5'd18;
  localparam logic [4:0] ST_LIGHT       = 5'd19;
  localparam logic [4:0] ST_VENT        = 5'd20;
  localparam logic [4:0] ST_SEND_STATUS = 5'd21;
  localparam logic [4:0] ST_ALARM       = 5'd22;
  localparam logic [4:0] ST_MAINT       = 5'd23;

  // operating modes
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MAINT  = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // recheck kinds
  localparam logic [1:0] RECHECK_NONE = 2'd0;
  localparam logic [1:0] RECHECK_PH   = 2'd1;
  localparam logic [1:0] RECHECK_TDS  = 2'd2;

  // relay masks
  localparam logic [5:0] RLY_NONE    = 6'h00;
  localparam logic [5:0] RLY_PH_UP   = 6'h01;
  localparam logic [5:0] RLY_PH_DOWN = 6'h02;
  localparam logic [5:0] RLY_PUMP_A  = 6'h04;
  localparam logic [5:0] RLY_PUMP_B  = 6'h08;
  localparam logic [5:0] RLY_RECIRC  = 6'h10;
  localparam logic [5:0] RLY_WATER   = 6'h20;

  // alarm codes
  localparam logic [3:0] ALM_NONE      = 4'd0;
  localparam logic [3:0] ALM_RTC       = 4'd1;
  localparam logic [3:0] ALM_PH_SENSOR = 4'd3;
  localparam logic [3:0] ALM_TDS_SENSOR = 4'd4;
  localparam logic [3:0] ALM_FILL      = 4'd7;
  localparam logic [3:0] ALM_LIMIT     = 4'd8;
  localparam logic [3:0] ALM_STABILIZE = 4'd9;

  // sensor check codes
  localparam logic [2:0] CHK_OK       = 3'd0;
  localparam logic [2:0] CHK_LAST_BAD = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_PH_TARGET    = 3'd0;
  localparam logic [2:0] CFG_PH_TOL       = 3'd1;
  localparam logic [2:0] CFG_TDS_TARGET   = 3'd2;
  localparam logic [2:0] CFG_TDS_TOL      = 3'd3;
  localparam logic [2:0] CFG_MAX_CORR     = 3'd4;
  localparam logic [2:0] CFG_PH_DOSE      = 3'd5;
  localparam logic [2:0] CFG_NUTRIENT_DOSE = 3'd6;
  localparam logic [2:0] CFG_STABILIZE    = 3'd7;

  localparam logic [32:0] STAB_GRACE_MS = 33'd90000;

  typedef struct packed {
    logic [10:0] ph_target;
    logic [10:0] ph_tolerance;
    logic [13:0] tds_target;
    logic [13:0] tds_tolerance;
    logic [7:0]  max_corrections;
    logic [15:0] ph_dose_ms;
    logic [15:0] nutrient_dose_ms;
    logic [31:0] stabilize_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  mode;
    logic        startup_lock;
    logic        alarm_active;
    logic        rtc_ok;
    logic [2:0]  sensor_check;
    logic [10:0] ph_value;
    logic        ph_ok;
    logic [13:0] tds_value;
    logic        tds_ok;
    logic        level_min;
    logic        level_max;
  } in_item_t;

  typedef struct packed {
    logic [4:0] state_code;
    logic [5:0] relays;
    logic [3:0] alarm_raise;
    logic       low_level_notice;
    logic       poll_request;
    logic       status_request;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  seq_state;
    logic [31:0] entered_at;
    logic [31:0] action_time;
    logic [7:0]  ph_attempts;
    logic [7:0]  tds_attempts;
    logic [1:0]  recheck_kind;
    logic [5:0]  relay_bits;
    logic [1:0]  prior_mode;
  } seq_t;

endpackage
`default_nettype wire

// ----- design/nutrient_dosing_sequencer_top.sv -----
// Nutrient dosing sequencer. Every input item is one tick (time, mode, alarm flag and a
// sensor snapshot) and yields exactly one result item: the sequencer state after the
// tick, the six relay states, an alarm code raised on that tick and three request
// pulses. An item is registered in the input register on acceptance, and its result is
// registered in the output register once the output may advance. One item per clock is
// sustained while the output is not stalled; the state update for a tick is a single
// pass of compares and selects. A stalled output holds its result while the next item
// waits in the input register. Configuration writes take effect on the next processed
// tick and should be issued only while idle.
`default_nettype none
module nutrient_dosing_sequencer_top
  import nds_pkg::*;
#(
  parameter int unsigned RECIRC_MS       = 30000,
  parameter int unsigned FILL_TIMEOUT_MS = 300000,
  parameter int unsigned DOSE_TIMEOUT_MS = 10000
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // now_ms[31:0], mode[33:32], startup_lock[34], alarm_active[35], rtc_ok[36],
  // sensor_check[39:37], ph_value[50:40], ph_ok[51], tds_value[65:52], tds_ok[66],
  // level_min[67], level_max[68], zero fill above
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // state_code[4:0], ph_up_on[5], ph_down_on[6], pump_a_on[7], pump_b_on[8],
  // recirc_on[9], water_in_on[10], alarm_raise[14:11], low_level_notice[15],
  // poll_request[16], status_request[17], zero fill above
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_valid;
  seq_t      seq;
  seq_t      seq_next;
  out_item_t res_next;
  out_item_t out_reg;
  logic      advance;

  assign cfg_ready = !rst;

  nds_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg.now_ms       <= s_axis_tdata[31:0];
      in_reg.mode         <= s_axis_tdata[33:32];
      in_reg.startup_lock <= s_axis_tdata[34];
      in_reg.alarm_active <= s_axis_tdata[35];
      in_reg.rtc_ok       <= s_axis_tdata[36];
      in_reg.sensor_check <= s_axis_tdata[39:37];
      in_reg.ph_value     <= s_axis_tdata[50:40];
      in_reg.ph_ok        <= s_axis_tdata[51];
      in_reg.tds_value    <= s_axis_tdata[65:52];
      in_reg.tds_ok       <= s_axis_tdata[66];
      in_reg.level_min    <= s_axis_tdata[67];
      in_reg.level_max    <= s_axis_tdata[68];
    end
  end

  nds_step #(
    .RECIRC_MS       (RECIRC_MS),
    .FILL_TIMEOUT_MS (FILL_TIMEOUT_MS),
    .DOSE_TIMEOUT_MS (DOSE_TIMEOUT_MS)
  ) u_step (
    .cur  (seq),
    .item (in_reg),
    .cfg  (cfg),
    .nxt  (seq_next),
    .res  (res_next)
  );

  // sequencer state commits together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq.seq_state    <= ST_MAINT;
      seq.entered_at   <= '0;
      seq.action_time  <= '0;
      seq.ph_attempts  <= '0;
      seq.tds_attempts <= '0;
      seq.recheck_kind <= RECHECK_NONE;
      seq.relay_bits   <= RLY_NONE;
      seq.prior_mode   <= MODE_MAINT;
      m_axis_tvalid    <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
      if (in_valid) seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) out_reg <= res_next;
  end

  assign m_axis_tdata = {6'd0, out_reg.status_request, out_reg.poll_request,
                         out_reg.low_level_notice, out_reg.alarm_raise,
                         out_reg.relays, out_reg.state_code};

endmodule
`default_nettype wire

// ----- design/nds_cfg.sv -----
`default_nettype none
module nds_cfg
  import nds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ph_target        <= 11'd600;
      cfg.ph_tolerance     <= 11'd30;
      cfg.tds_target       <= 14'd800;
      cfg.tds_tolerance    <= 14'd50;
      cfg.max_corrections  <= 8'd3;
      cfg.ph_dose_ms       <= 16'd1000;
      cfg.nutrient_dose_ms <= 16'd1000;
      cfg.stabilize_ms     <= 32'd60000;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PH_TARGET:     cfg.ph_target        <= wr_data[10:0];
        CFG_PH_TOL:        cfg.ph_tolerance     <= wr_data[10:0];
        CFG_TDS_TARGET:    cfg.tds_target       <= wr_data[13:0];
        CFG_TDS_TOL:       cfg.tds_tolerance    <= wr_data[13:0];
        CFG_MAX_CORR:      cfg.max_corrections  <= wr_data[7:0];
        CFG_PH_DOSE:       cfg.ph_dose_ms       <= wr_data[15:0];
        CFG_NUTRIENT_DOSE: cfg.nutrient_dose_ms <= wr_data[15:0];
        CFG_STABILIZE:     cfg.stabilize_ms     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/nds_step.sv -----
`default_nettype none
module nds_step
  import nds_pkg::*;
#(
  parameter int unsigned RECIRC_MS       = 30000,
  parameter int unsigned FILL_TIMEOUT_MS = 300000,
  parameter int unsigned DOSE_TIMEOUT_MS = 10000
) (
  input  wire seq_t     cur,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output seq_t          nxt,
  output out_item_t     res
);

  localparam logic [31:0] RECIRC_T = 32'(RECIRC_MS);
  localparam logic [31:0] FILL_T   = 32'(FILL_TIMEOUT_MS);
  localparam logic [31:0] DOSE_T   = 32'(DOSE_TIMEOUT_MS);

  logic [1:0]  mode;
  logic [4:0]  mid_state;
  logic [31:0] mid_entered;
  logic [31:0] elapsed;
  logic        expired;
  logic        timed_out;
  logic        ph_low;
  logic        ph_high;
  logic        tds_low;
  logic        stab_over;
  logic        sensor_bad;
  logic [3:0]  alarm_code;
  logic        notice;
  logic        poll;
  logic        status;

  // threshold tests without signed subtraction
  assign ph_low  = ({1'b0, item.ph_value} + {1'b0, cfg.ph_tolerance}) < {1'b0, cfg.ph_target};
  assign ph_high = {1'b0, item.ph_value} > ({1'b0, cfg.ph_target} + {1'b0, cfg.ph_tolerance});
  assign tds_low = ({1'b0, item.tds_value} + {1'b0, cfg.tds_tolerance})
                   < {1'b0, cfg.tds_target};
  assign sensor_bad = (item.sensor_check != CHK_OK) && (item.sensor_check <= CHK_LAST_BAD);

  always_comb begin
    mode = (item.mode == MODE_RSVD) ? MODE_MANUAL : item.mode;
    nxt = cur;
    alarm_code = ALM_NONE;
    notice = 1'b0;
    poll = 1'b0;
    status = 1'b0;

    // mode change comes first
    if (mode != cur.prior_mode) begin
      nxt.prior_mode = mode;
      if (mode != MODE_AUTO) begin
        nxt.ph_attempts = '0;
        nxt.tds_attempts = '0;
      end
      if (mode == MODE_MAINT) begin
        nxt.relay_bits = RLY_NONE;
        nxt.seq_state = ST_MAINT;
      end else if (mode == MODE_AUTO) begin
        nxt.seq_state = ST_READ;
      end else begin
        nxt.seq_state = item.startup_lock ? ST_SAFE_IDLE : ST_MANUAL_IDLE;
      end
      if (nxt.seq_state != cur.seq_state) nxt.entered_at = item.now_ms;
    end

    mid_state   = nxt.seq_state;
    mid_entered = nxt.entered_at;
    elapsed     = item.now_ms - mid_entered;
    expired     = elapsed >= cur.action_time;
    timed_out   = expired || (elapsed >= DOSE_T);
    stab_over   = {1'b0, elapsed} > ({1'b0, cfg.stabilize_ms} + STAB_GRACE_MS);

    if (item.alarm_active) begin
      nxt.seq_state = ST_ALARM;
    end else if (mode == MODE_MAINT) begin
      nxt.seq_state = ST_MAINT;
    end else if (mode == MODE_MANUAL) begin
      nxt.seq_state = item.startup_lock ? ST_SAFE_IDLE : ST_MANUAL_IDLE;
    end else begin
      unique case (mid_state)
        ST_BOOT, ST_SAFE_IDLE, ST_MANUAL_IDLE, ST_AUTO_IDLE: begin
          nxt.seq_state = ST_READ;
        end
        ST_READ: begin
          poll = 1'b1;
          nxt.seq_state = ST_VALIDATE;
        end
        ST_VALIDATE: begin
          if (!item.rtc_ok) begin
            alarm_code = ALM_RTC;
            nxt.seq_state = ST_ALARM;
          end else if (sensor_bad) begin
            alarm_code = {1'b0, item.sensor_check} + 4'd1;
            nxt.seq_state = ST_ALARM;
          end else begin
            nxt.seq_state = ST_CHECK_LEVEL;
          end
        end
        ST_CHECK_LEVEL: begin
          if (item.level_min && !item.level_max) begin
            notice = 1'b1;
            nxt.recheck_kind = RECHECK_PH;
            nxt.relay_bits = RLY_WATER;
            nxt.action_time = FILL_T;
            nxt.seq_state = ST_FILL;
          end else begin
            nxt.seq_state = ST_EVAL_PH;
          end
        end
        ST_FILL: begin
          if (item.level_max) begin
            nxt.relay_bits = cur.relay_bits & ~RLY_WATER;
            nxt.recheck_kind = RECHECK_PH;
            nxt.seq_state = ST_WAIT_STAB;
          end else if (expired) begin
            nxt.relay_bits = cur.relay_bits & ~RLY_WATER;
            alarm_code = ALM_FILL;
            nxt.seq_state = ST_ALARM;
          end
        end
        ST_EVAL_PH: begin
          if (!item.ph_ok) begin
            alarm_code = ALM_PH_SENSOR;
            nxt.seq_state = ST_ALARM;
          end else if (ph_low || ph_high) begin
            if (nxt.ph_attempts >= cfg.max_corrections) begin
              alarm_code = ALM_LIMIT;
              nxt.seq_state = ST_ALARM;
            end else begin
              nxt.ph_attempts = nxt.ph_attempts + 8'd1;
              nxt.recheck_kind = RECHECK_PH;
              nxt.action_time = {16'd0, cfg.ph_dose_ms};
              nxt.relay_bits = ph_low ? RLY_PH_UP : RLY_PH_DOWN;
              nxt.seq_state = ph_low ? ST_DOSE_UP : ST_DOSE_DOWN;
            end
          end else begin
            nxt.ph_attempts = '0;
            nxt.seq_state = ST_EVAL_TDS;
          end
        end
        ST_DOSE_UP, ST_DOSE_DOWN: begin
          if (timed_out) begin
            nxt.relay_bits = RLY_RECIRC;
            nxt.action_time = RECIRC_T;
            nxt.seq_state = ST_RECIRC_PH;
          end
        end
        ST_RECIRC_PH, ST_RECIRC_B: begin
          if (expired) begin
            nxt.relay_bits = cur.relay_bits & ~RLY_RECIRC;
            nxt.seq_state = ST_WAIT_STAB;
          end
        end
        ST_EVAL_TDS: begin
          if (!item.tds_ok) begin
            alarm_code = ALM_TDS_SENSOR;
            nxt.seq_state = ST_ALARM;
          end else if (tds_low) begin
            if (nxt.tds_attempts >= cfg.max_corrections) begin
              alarm_code = ALM_LIMIT;
              nxt.seq_state = ST_ALARM;
            end else begin
              nxt.tds_attempts = nxt.tds_attempts + 8'd1;
              nxt.recheck_kind = RECHECK_TDS;
              nxt.action_time = {16'd0, cfg.nutrient_dose_ms};
              nxt.relay_bits = RLY_PUMP_A;
              nxt.seq_state = ST_DOSE_A;
            end
          end else begin
            nxt.tds_attempts = '0;
            nxt.seq_state = ST_LIGHT;
          end
        end
        ST_DOSE_A: begin
          if (timed_out) begin
            nxt.relay_bits = RLY_RECIRC;
            nxt.action_time = RECIRC_T;
            nxt.seq_state = ST_RECIRC_A;
          end
        end
        ST_RECIRC_A: begin
          if (expired) begin
            nxt.relay_bits = RLY_PUMP_B;
            nxt.action_time = {16'd0, cfg.nutrient_dose_ms};
            nxt.seq_state = ST_DOSE_B;
          end
        end
        ST_DOSE_B: begin
          if (timed_out) begin
            nxt.relay_bits = RLY_RECIRC;
            nxt.action_time = RECIRC_T;
            nxt.seq_state = ST_RECIRC_B;
          end
        end
        ST_WAIT_STAB: begin
          if (stab_over) begin
            alarm_code = ALM_STABILIZE;
            nxt.seq_state = ST_ALARM;
          end else if (elapsed >= cfg.stabilize_ms) begin
            nxt.seq_state = ST_REMEASURE;
          end
        end
        ST_REMEASURE: begin
          poll = 1'b1;
          nxt.seq_state = (cur.recheck_kind == RECHECK_PH) ? ST_EVAL_PH : ST_EVAL_TDS;
        end
        ST_LIGHT: nxt.seq_state = ST_VENT;
        ST_VENT:  nxt.seq_state = ST_SEND_STATUS;
        ST_SEND_STATUS: begin
          status = 1'b1;
          nxt.recheck_kind = RECHECK_NONE;
          nxt.seq_state = ST_AUTO_IDLE;
        end
        default: ;
      endcase
    end

    // entry time moves only on a real state change
    if (nxt.seq_state != mid_state) nxt.entered_at = item.now_ms;

    res.state_code       = nxt.seq_state;
    res.relays           = nxt.relay_bits;
    res.alarm_raise      = alarm_code;
    res.low_level_notice = notice;
    res.poll_request     = poll;
    res.status_request   = status;
  end

endmodule
`default_nettype wire

// ----- design/nds_checker.sv -----
`default_nettype none
module nds_port_props
  import nds_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // never more than one relay on
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[10:5]))
    else $error("several relays on at once");

  // maintenance keeps every relay off
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4:0] == ST_MAINT |-> m_axis_tdata[10:5] == RLY_NONE)
    else $error("relay on in maintenance");

  // a raised alarm lands in the alarm state
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[14:11] != ALM_NONE |-> m_axis_tdata[4:0] == ST_ALARM)
    else $error("alarm raised outside alarm state");

  // poll and status pulses only on their own transitions
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16] || m_axis_tdata[17]) |->
      (m_axis_tdata[16] && (m_axis_tdata[4:0] == ST_VALIDATE ||
        m_axis_tdata[4:0] == ST_EVAL_PH || m_axis_tdata[4:0] == ST_EVAL_TDS)) ||
      (m_axis_tdata[17] && m_axis_tdata[4:0] == ST_AUTO_IDLE))
    else $error("request pulse in unexpected state");

endmodule

bind nutrient_dosing_sequencer_top nds_port_props u_nds_port_props (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
